[rtl/core/json_array_stream_validator_top_assert.svh]
// Assertion macros used by the validator back end.
`ifndef JSON_ARRAY_STREAM_VALIDATOR_TOP_ASSERT_SVH
`define JSON_ARRAY_STREAM_VALIDATOR_TOP_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define JASV_CHECK(label, clk_sig, rst_sig, expr, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (expr)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define JASV_IMPLY(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define JASV_IMPLY_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/jasv_pkg.sv]
// Shared types, constants and functions of the JSON array stream validator.
package jasv_pkg;

    localparam int MAX_DEPTH_DEFAULT = 64;
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] DEPTH_LIMIT_RESET = 7'd64;
    localparam int DEPTH_HARD_CAP = 127;

    // Queue between front and back; the depth must be a power of two.
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LE     = 8'h65;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_LL     = 8'h6C;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LS     = 8'h73;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LU     = 8'h75;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UE     = 8'h45;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [4:0] {
        M_START,
        M_ELEM,
        M_AFTER,
        M_STR,
        M_ESC,
        M_HEX,
        M_LIT,
        M_NEG,
        M_ZERO,
        M_INT,
        M_DOT,
        M_FRAC,
        M_E,
        M_ESIGN,
        M_EXP,
        M_DONE
    } scan_mode_t;

    typedef enum logic [2:0] {
        V_PEND = 3'd0,
        V_OK   = 3'd1,
        V_SYN  = 3'd2,
        V_OBJ  = 3'd3,
        V_DEEP = 3'd4
    } verdict_t;

    typedef enum logic [1:0] {
        LIT_TRUE  = 2'd0,
        LIT_FALSE = 2'd1,
        LIT_NULL  = 2'd2
    } lit_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic       document_end;
    } out_item_t;

    // Byte classes worked out by the front end.
    typedef struct packed {
        logic      lbrack;
        logic      rbrack;
        logic      lbrace;
        logic      quote;
        logic      bslash;
        logic      comma;
        logic      minus;
        logic      plus;
        logic      dot;
        logic      zero;
        logic      digit;
        logic      hex;
        logic      ctrl;
        logic      esc;
        logic      expmark;
        logic      uchar;
        logic      lit_start;
        lit_kind_t lit_kind;
    } byte_class_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        byte_class_t cls;
    } queue_entry_t;

    function automatic logic [2:0] lit_len(input lit_kind_t kind);
        logic [2:0] len;
        case (kind)
            LIT_FALSE: len = 3'd5;
            default:   len = 3'd4;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] lit_char(input lit_kind_t kind, input logic [2:0] pos);
        logic [7:0] ch;
        ch = CH_NUL;
        case (kind)
            LIT_TRUE:
            begin
                case (pos)
                    3'd0:    ch = CH_LT;
                    3'd1:    ch = CH_LR;
                    3'd2:    ch = CH_LU;
                    3'd3:    ch = CH_LE;
                    default: ch = CH_NUL;
                endcase
            end
            LIT_FALSE:
            begin
                case (pos)
                    3'd0:    ch = CH_LF;
                    3'd1:    ch = CH_LA;
                    3'd2:    ch = CH_LL;
                    3'd3:    ch = CH_LS;
                    3'd4:    ch = CH_LE;
                    default: ch = CH_NUL;
                endcase
            end
            LIT_NULL:
            begin
                case (pos)
                    3'd0:    ch = CH_LN;
                    3'd1:    ch = CH_LU;
                    3'd2:    ch = CH_LL;
                    3'd3:    ch = CH_LL;
                    default: ch = CH_NUL;
                endcase
            end
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

[rtl/core/json_array_stream_validator_top.sv]
// Top level of the JSON array stream validator: front end, queue, scanner and register.
//
// The validator checks a document that arrives one byte per request and answers every
// byte with one result request carrying a verdict (pending, valid, syntax error, object
// unsupported, too deep) and an echo of the final-byte mark; the verdict on the final
// byte is the document's answer, and the scanner then restarts for the next document.
// The top level must be an array, whitespace is rejected, a trailing comma before a
// closing bracket is accepted and bytes after the closing bracket are ignored.
// Throughput is one byte per clock cycle sustained while the output is not stalled,
// set by the scanner state machine, which updates its state and depth counter once per
// byte. An accepted byte is written into a four-entry queue, taken by the scanner when
// the result register can take it, and its result is shown from the result register.
// The queue lets input requests keep flowing while a result waits on the output side;
// input ready drops only when the queue is full.
// The nesting limit register depth_limit is written through the cfg channel, which is
// always ready; a limit of zero acts as one and the limit is capped by MAX_DEPTH and
// by 127. Write it only while no document is in flight. No clearing pass follows reset.
module json_array_stream_validator_top #(
    parameter int MAX_DEPTH = jasv_pkg::MAX_DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  jasv_pkg::in_item_t         in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output jasv_pkg::out_item_t        out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [jasv_pkg::CFG_W-1:0] cfg_data
);
    import jasv_pkg::*;

    logic             cfg_write;
    logic [CFG_W-1:0] depth_limit_reg;
    logic             queue_full;
    logic             queue_not_empty;
    logic             push;
    logic             pop;
    queue_entry_t     push_entry;
    queue_entry_t     head;

    // The single configuration register takes every write request at once.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_limit_reg <= DEPTH_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            depth_limit_reg <= cfg_data;
        end
    end

    // Front end: accept input requests and classify each byte.
    jasv_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue that decouples input acceptance from the scanner.
    jasv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .not_empty  (queue_not_empty),
        .pop        (pop),
        .head       (head)
    );

    // Back end: scanner state machine, depth counter and result register.
    jasv_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .depth_limit (depth_limit_reg),
        .entry_valid (queue_not_empty),
        .entry       (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

[rtl/core/jasv_front.sv]
// Front end: accepts input requests and classifies each byte for the scanner.
module jasv_front (
    input  logic                   in_valid,
    output logic                   in_ready,
    input  jasv_pkg::in_item_t     in_data,
    input  logic                   queue_full,
    output logic                   push,
    output jasv_pkg::queue_entry_t push_entry
);
    import jasv_pkg::*;

    logic [7:0]  b;
    byte_class_t cls;

    assign b = in_data.data_byte;

    always_comb
    begin
        cls.lbrack    = (b == CH_LBRACK);
        cls.rbrack    = (b == CH_RBRACK);
        cls.lbrace    = (b == CH_LBRACE);
        cls.quote     = (b == CH_QUOTE);
        cls.bslash    = (b == CH_BSLASH);
        cls.comma     = (b == CH_COMMA);
        cls.minus     = (b == CH_MINUS);
        cls.plus      = (b == CH_PLUS);
        cls.dot       = (b == CH_DOT);
        cls.zero      = (b == CH_0);
        cls.digit     = (b inside {[CH_0:CH_9]});
        cls.hex       = (b inside {[CH_0:CH_9], [CH_LA:CH_LF], [CH_UA:CH_UF]});
        cls.ctrl      = (b < CH_SPACE);
        cls.esc       = (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LB, CH_LN, CH_LF,
                                   CH_LR, CH_LT});
        cls.expmark   = (b == CH_LE) || (b == CH_UE);
        cls.uchar     = (b == CH_LU);
        cls.lit_start = (b inside {CH_LT, CH_LF, CH_LN});
        if (b == CH_LT)
        begin
            cls.lit_kind = LIT_TRUE;
        end
        else if (b == CH_LF)
        begin
            cls.lit_kind = LIT_FALSE;
        end
        else
        begin
            cls.lit_kind = LIT_NULL;
        end
    end

    assign in_ready             = !queue_full;
    assign push                 = in_valid && !queue_full;
    assign push_entry.data_byte = in_data.data_byte;
    assign push_entry.last_byte = in_data.last_byte;
    assign push_entry.cls       = cls;

endmodule

[rtl/core/jasv_queue.sv]
// Short queue of classified bytes between the front end and the scanner.
module jasv_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  jasv_pkg::queue_entry_t push_entry,
    output logic                   full,
    output logic                   not_empty,
    input  logic                   pop,
    output jasv_pkg::queue_entry_t head
);
    import jasv_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    queue_entry_t     slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full      = (count_reg == (PTR_W + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[rtl/core/jasv_back.sv]
// Back end: the byte scanner state machine, depth counter and result register.
module jasv_back #(
    parameter int MAX_DEPTH = jasv_pkg::MAX_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [jasv_pkg::CFG_W-1:0]    depth_limit,
    input  logic                          entry_valid,
    input  jasv_pkg::queue_entry_t        entry,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output jasv_pkg::out_item_t           out_data
);
    import jasv_pkg::*;

    `include "json_array_stream_validator_top_assert.svh"

    localparam int DEPTH_CAP_INT = (MAX_DEPTH > DEPTH_HARD_CAP) ? DEPTH_HARD_CAP : MAX_DEPTH;
    localparam int DEPTH_W = $clog2(DEPTH_CAP_INT + 1);
    localparam logic [CFG_W-1:0] DEPTH_CAP = CFG_W'(DEPTH_CAP_INT);

    scan_mode_t         mode_reg, mode_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [2:0]         pos_reg, pos_next;
    lit_kind_t          kind_reg, kind_next;
    verdict_t           verd_reg, verd_next;

    logic               out_valid_reg;
    out_item_t          out_item_reg, out_item_next;
    logic [CFG_W-1:0]   lim;

    assign pop = entry_valid && (!out_valid_reg || out_ready);

    // Effective nesting limit: capped by the build-time maximum, zero acts as one.
    always_comb
    begin
        lim = (depth_limit > DEPTH_CAP) ? DEPTH_CAP : depth_limit;
        if (lim == '0)
        begin
            lim = CFG_W'(1);
        end
    end

    always_comb
    begin
        logic               open_req;
        logic               close_req;
        logic               after_req;
        logic               fail_req;
        verdict_t           fail_code;
        logic [DEPTH_W-1:0] depth_dec;
        logic [2:0]         len;
        logic [2:0]         pos_inc;
        verdict_t           v;

        mode_next  = mode_reg;
        depth_next = depth_reg;
        pos_next   = pos_reg;
        kind_next  = kind_reg;
        verd_next  = verd_reg;
        open_req   = 1'b0;
        close_req  = 1'b0;
        after_req  = 1'b0;
        fail_req   = 1'b0;
        fail_code  = V_SYN;
        len        = lit_len(kind_reg);
        pos_inc    = pos_reg + 3'd1;
        depth_dec  = (depth_reg != '0) ? depth_reg - 1'b1 : '0;

        if (pop && (verd_reg == V_PEND))
        begin
            case (mode_reg)
                M_START:
                begin
                    if (entry.cls.lbrack)
                    begin
                        open_req = 1'b1;
                    end
                    else
                    begin
                        fail_req  = 1'b1;
                        fail_code = entry.cls.lbrace ? V_OBJ : V_SYN;
                    end
                end
                M_ELEM:
                begin
                    if (entry.cls.lbrack)
                    begin
                        open_req = 1'b1;
                    end
                    else if (entry.cls.lbrace)
                    begin
                        fail_req  = 1'b1;
                        fail_code = V_OBJ;
                    end
                    else if (entry.cls.quote)
                    begin
                        mode_next = M_STR;
                    end
                    else if (entry.cls.minus)
                    begin
                        mode_next = M_NEG;
                    end
                    else if (entry.cls.zero)
                    begin
                        mode_next = M_ZERO;
                    end
                    else if (entry.cls.digit)
                    begin
                        mode_next = M_INT;
                    end
                    else if (entry.cls.lit_start)
                    begin
                        kind_next = entry.cls.lit_kind;
                        pos_next  = 3'd1;
                        mode_next = M_LIT;
                    end
                    else if (entry.cls.rbrack)
                    begin
                        close_req = 1'b1;
                    end
                    else
                    begin
                        fail_req = 1'b1;
                    end
                end
                M_AFTER:
                begin
                    after_req = 1'b1;
                end
                M_STR:
                begin
                    if (entry.cls.ctrl)
                    begin
                        fail_req = 1'b1;
                    end
                    else if (entry.cls.bslash)
                    begin
                        mode_next = M_ESC;
                    end
                    else if (entry.cls.quote)
                    begin
                        mode_next = M_AFTER;
                    end
                end
                M_ESC:
                begin
                    if (entry.cls.uchar)
                    begin
                        mode_next = M_HEX;
                        pos_next  = 3'd0;
                    end
                    else if (entry.cls.esc)
                    begin
                        mode_next = M_STR;
                    end
                    else
                    begin
                        fail_req = 1'b1;
                    end
                end
                M_HEX:
                begin
                    if (!entry.cls.hex)
                    begin
                        fail_req = 1'b1;
                    end
                    else if (pos_reg == 3'd3)
                    begin
                        pos_next  = 3'd0;
                        mode_next = M_STR;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                    end
                end
                M_LIT:
                begin
                    if ((pos_reg >= len) || (entry.data_byte != lit_char(kind_reg, pos_reg)))
                    begin
                        fail_req = 1'b1;
                    end
                    else if (pos_inc >= len)
                    begin
                        pos_next  = 3'd0;
                        mode_next = M_AFTER;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                    end
                end
                M_NEG:
                begin
                    if (entry.cls.zero)
                    begin
                        mode_next = M_ZERO;
                    end
                    else if (entry.cls.digit)
                    begin
                        mode_next = M_INT;
                    end
                    else
                    begin
                        fail_req = 1'b1;
                    end
                end
                M_ZERO:
                begin
                    if (entry.cls.dot)
                    begin
                        mode_next = M_DOT;
                    end
                    else if (entry.cls.expmark)
                    begin
                        mode_next = M_E;
                    end
                    else
                    begin
                        after_req = 1'b1;
                    end
                end
                M_INT:
                begin
                    if (entry.cls.digit)
                    begin
                        mode_next = M_INT;
                    end
                    else if (entry.cls.dot)
                    begin
                        mode_next = M_DOT;
                    end
                    else if (entry.cls.expmark)
                    begin
                        mode_next = M_E;
                    end
                    else
                    begin
                        after_req = 1'b1;
                    end
                end
                M_DOT:
                begin
                    if (entry.cls.digit)
                    begin
                        mode_next = M_FRAC;
                    end
                    else
                    begin
                        fail_req = 1'b1;
                    end
                end
                M_FRAC:
                begin
                    if (entry.cls.digit)
                    begin
                        mode_next = M_FRAC;
                    end
                    else if (entry.cls.expmark)
                    begin
                        mode_next = M_E;
                    end
                    else
                    begin
                        after_req = 1'b1;
                    end
                end
                M_E:
                begin
                    if (entry.cls.plus || entry.cls.minus)
                    begin
                        mode_next = M_ESIGN;
                    end
                    else if (entry.cls.digit)
                    begin
                        mode_next = M_EXP;
                    end
                    else
                    begin
                        fail_req = 1'b1;
                    end
                end
                M_ESIGN:
                begin
                    if (entry.cls.digit)
                    begin
                        mode_next = M_EXP;
                    end
                    else
                    begin
                        fail_req = 1'b1;
                    end
                end
                M_EXP:
                begin
                    if (!entry.cls.digit)
                    begin
                        after_req = 1'b1;
                    end
                end
                M_DONE:
                begin
                    mode_next = M_DONE;
                end
                default:
                begin
                    fail_req = 1'b1;
                end
            endcase

            // A value has ended: only a separator or a closing bracket may follow.
            if (after_req)
            begin
                if (entry.cls.comma)
                begin
                    mode_next = M_ELEM;
                end
                else if (entry.cls.rbrack)
                begin
                    close_req = 1'b1;
                end
                else
                begin
                    fail_req = 1'b1;
                end
            end

            if (open_req)
            begin
                if (CFG_W'(depth_reg) >= lim)
                begin
                    fail_req  = 1'b1;
                    fail_code = V_DEEP;
                end
                else
                begin
                    depth_next = depth_reg + 1'b1;
                    mode_next  = M_ELEM;
                end
            end

            if (close_req)
            begin
                depth_next = depth_dec;
                if (depth_dec == '0)
                begin
                    mode_next = M_DONE;
                    verd_next = V_OK;
                end
                else
                begin
                    mode_next = M_AFTER;
                end
            end

            if (fail_req)
            begin
                verd_next = fail_code;
                mode_next = M_DONE;
            end
        end

        // A document that ends while still pending is incomplete.
        v = verd_next;
        if (entry.last_byte && (v == V_PEND))
        begin
            v = V_SYN;
        end
        out_item_next.verdict      = v;
        out_item_next.document_end = entry.last_byte;

        if (pop && entry.last_byte)
        begin
            mode_next  = M_START;
            depth_next = '0;
            pos_next   = 3'd0;
            kind_next  = LIT_TRUE;
            verd_next  = V_PEND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_START;
            depth_reg <= '0;
            pos_reg   <= 3'd0;
            kind_reg  <= LIT_TRUE;
            verd_reg  <= V_PEND;
        end
        else
        begin
            mode_reg  <= mode_next;
            depth_reg <= depth_next;
            pos_reg   <= pos_next;
            kind_reg  <= kind_next;
            verd_reg  <= verd_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    `JASV_CHECK(a_depth_cap, clk, rst_n, CFG_W'(depth_reg) <= DEPTH_CAP, "nesting depth above cap")
    `JASV_CHECK(a_done_matches_verdict, clk, rst_n, (mode_reg == M_DONE) == (verd_reg != V_PEND), "done state and verdict disagree")
    `JASV_IMPLY(a_hex_count, clk, rst_n, mode_reg == M_HEX, pos_reg < 3'd4, "hex digit count out of range")
    `JASV_IMPLY_NEXT(a_restart, clk, rst_n, pop && entry.last_byte, (mode_reg == M_START) && (depth_reg == '0) && (verd_reg == V_PEND), "scanner did not restart after final byte")
    `JASV_IMPLY_NEXT(a_result_follows, clk, rst_n, pop, out_valid_reg, "taken byte produced no result")

endmodule

[bench/json_array_stream_validator_top_tb.sv]
// Self-checking testbench of the JSON array stream validator top level.
module json_array_stream_validator_top_tb;
    import jasv_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 4;
    localparam int BYTE_GOAL = 1650;
    localparam int CHUNK_COUNT = 9;
    localparam int MISMATCH_SHOW = 10;
    localparam int SETTLE_CYCLES = 4;
    localparam int WATCHDOG_TIME = 4000000;

    // All inputs of the block hold known values from time zero on.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;

    // Bytes waiting to be offered, verdicts waiting to come back, and the document being built.
    in_item_t bytes_pending[$];
    out_item_t verdicts_due[$];
    logic [7:0] doc_buf[$];

    int bytes_queued = 0;
    int verdicts_checked = 0;
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Depth limits used by the random chunks, the extremes among them. A limit of 127 is
    // capped to the depth parameter, and a limit of 0 behaves like 1.
    logic [CFG_W-1:0] limit_plan [CHUNK_COUNT] =
        '{7'd3, 7'd0, 7'd127, 7'd2, 7'd64, 7'd5, 7'd1, 7'd4, 7'd96};

    // Scanner state as the testbench sees it, kept apart from the block.
    scan_mode_t scan_state;
    verdict_t held_verdict;
    int unsigned level;
    int unsigned lit_pos;
    lit_kind_t lit_sel;
    logic [CFG_W-1:0] limit_reg;
    string lit_words [3] = '{"true", "false", "null"};

    json_array_stream_validator_top #(
        .MAX_DEPTH(MAX_DEPTH_DEFAULT)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // Verdict prediction
    // ------------------------------------------------------------------

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_hex(logic [7:0] c);
        return is_digit(c) || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
    endfunction

    // The nesting depth that a register value really allows.
    function automatic int unsigned allowed_depth(logic [CFG_W-1:0] v);
        int unsigned lim;
        lim = 32'(v);
        if (lim > MAX_DEPTH_DEFAULT)
            lim = MAX_DEPTH_DEFAULT;
        if (lim > DEPTH_HARD_CAP)
            lim = DEPTH_HARD_CAP;
        if (lim == 0)
            lim = 1;
        return lim;
    endfunction

    function automatic void restart_scan();
        scan_state = M_START;
        level = 0;
        lit_pos = 0;
        lit_sel = LIT_TRUE;
        held_verdict = V_PEND;
    endfunction

    // Once a verdict is reached it sticks until the final byte of the document.
    function automatic void settle(verdict_t v);
        held_verdict = v;
        scan_state = M_DONE;
    endfunction

    function automatic void push_level();
        if (level + 1 > allowed_depth(limit_reg))
            settle(V_DEEP);
        else
        begin
            level++;
            scan_state = M_ELEM;
        end
    endfunction

    // Closing the outermost array makes the document valid.
    function automatic void pop_level();
        if (level > 0)
            level--;
        if (level == 0)
        begin
            scan_state = M_DONE;
            held_verdict = V_OK;
        end
        else
            scan_state = M_AFTER;
    endfunction

    function automatic void after_element(logic [7:0] c);
        if (c == CH_COMMA)
            scan_state = M_ELEM;
        else if (c == CH_RBRACK)
            pop_level();
        else
            settle(V_SYN);
    endfunction

    function automatic void begin_literal(lit_kind_t k);
        lit_sel = k;
        lit_pos = 1;
        scan_state = M_LIT;
    endfunction

    // A ']' where an element should start closes the array, so a trailing comma passes.
    function automatic void begin_element(logic [7:0] c);
        if (c == CH_LBRACK)
            push_level();
        else if (c == CH_LBRACE)
            settle(V_OBJ);
        else if (c == CH_QUOTE)
            scan_state = M_STR;
        else if (c == CH_MINUS)
            scan_state = M_NEG;
        else if (c == CH_0)
            scan_state = M_ZERO;
        else if (is_digit(c))
            scan_state = M_INT;
        else if (c == CH_LT)
            begin_literal(LIT_TRUE);
        else if (c == CH_LF)
            begin_literal(LIT_FALSE);
        else if (c == CH_LN)
            begin_literal(LIT_NULL);
        else if (c == CH_RBRACK)
            pop_level();
        else
            settle(V_SYN);
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        string word;
        case (scan_state)
            M_START:
            begin
                if (c == CH_LBRACK)
                    push_level();
                else if (c == CH_LBRACE)
                    settle(V_OBJ);
                else
                    settle(V_SYN);
            end
            M_ELEM:
                begin_element(c);
            M_AFTER:
                after_element(c);
            M_STR:
            begin
                // Control bytes are errors; bytes of 0x80 and above pass.
                if (c < CH_SPACE)
                    settle(V_SYN);
                else if (c == CH_BSLASH)
                    scan_state = M_ESC;
                else if (c == CH_QUOTE)
                    scan_state = M_AFTER;
            end
            M_ESC:
            begin
                if (c == CH_LU)
                begin
                    scan_state = M_HEX;
                    lit_pos = 0;
                end
                else if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_LB ||
                         c == CH_LN || c == CH_LF || c == CH_LR || c == CH_LT)
                    scan_state = M_STR;
                else
                    settle(V_SYN);
            end
            M_HEX:
            begin
                if (!is_hex(c))
                    settle(V_SYN);
                else
                begin
                    lit_pos++;
                    if (lit_pos >= 4)
                    begin
                        lit_pos = 0;
                        scan_state = M_STR;
                    end
                end
            end
            M_LIT:
            begin
                word = lit_words[int'(lit_sel)];
                if (lit_pos >= word.len() || c != word[lit_pos])
                    settle(V_SYN);
                else
                begin
                    lit_pos++;
                    if (lit_pos >= word.len())
                    begin
                        lit_pos = 0;
                        scan_state = M_AFTER;
                    end
                end
            end
            M_NEG:
            begin
                if (c == CH_0)
                    scan_state = M_ZERO;
                else if (is_digit(c))
                    scan_state = M_INT;
                else
                    settle(V_SYN);
            end
            M_ZERO:
            begin
                // A leading zero followed by a digit falls through to a syntax error.
                if (c == CH_DOT)
                    scan_state = M_DOT;
                else if (c == CH_LE || c == CH_UE)
                    scan_state = M_E;
                else
                    after_element(c);
            end
            M_INT:
            begin
                if (c == CH_DOT)
                    scan_state = M_DOT;
                else if (c == CH_LE || c == CH_UE)
                    scan_state = M_E;
                else if (!is_digit(c))
                    after_element(c);
            end
            M_DOT:
            begin
                if (is_digit(c))
                    scan_state = M_FRAC;
                else
                    settle(V_SYN);
            end
            M_FRAC:
            begin
                if (c == CH_LE || c == CH_UE)
                    scan_state = M_E;
                else if (!is_digit(c))
                    after_element(c);
            end
            M_E:
            begin
                if (c == CH_PLUS || c == CH_MINUS)
                    scan_state = M_ESIGN;
                else if (is_digit(c))
                    scan_state = M_EXP;
                else
                    settle(V_SYN);
            end
            M_ESIGN:
            begin
                if (is_digit(c))
                    scan_state = M_EXP;
                else
                    settle(V_SYN);
            end
            M_EXP:
            begin
                if (!is_digit(c))
                    after_element(c);
            end
            M_DONE:
            begin
            end
            default:
                settle(V_SYN);
        endcase
    endfunction

    // Expected result for one accepted byte. A document still pending at its final byte
    // is incomplete, which is a syntax error, and the scan starts over afterwards.
    function automatic out_item_t judge_byte(in_item_t it);
        out_item_t res;
        verdict_t v;
        if (held_verdict == V_PEND)
            scan_byte(it.data_byte);
        v = held_verdict;
        if (it.last_byte && v == V_PEND)
            v = V_SYN;
        res.verdict = v;
        res.document_end = it.last_byte;
        if (it.last_byte)
            restart_scan();
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Document generation
    // ------------------------------------------------------------------

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            doc_buf.push_back(s[i]);
    endfunction

    function automatic void put_digit();
        doc_buf.push_back(8'(CH_0 + $urandom_range(0, 9)));
    endfunction

    // Strings mix printable text, high bytes, simple escapes, unicode escapes and, rarely,
    // a control byte that the block must reject.
    function automatic void gen_string();
        int n;
        int r;
        logic [7:0] c;
        string esc_set;
        string hex_set;
        esc_set = "\"\\/bfnrt";
        hex_set = "0123456789abcdefABCDEF";
        n = $urandom_range(0, 4);
        doc_buf.push_back(CH_QUOTE);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 39);
            if (r < 20)
            begin
                c = 8'($urandom_range(CH_SPACE, 8'h7E));
                if (c == CH_QUOTE || c == CH_BSLASH)
                    c = CH_LA;
                doc_buf.push_back(c);
            end
            else if (r < 27)
                doc_buf.push_back(8'($urandom_range(8'h80, 8'hFF)));
            else if (r < 33)
            begin
                doc_buf.push_back(CH_BSLASH);
                doc_buf.push_back(esc_set[$urandom_range(0, esc_set.len() - 1)]);
            end
            else if (r < 39)
            begin
                doc_buf.push_back(CH_BSLASH);
                doc_buf.push_back(CH_LU);
                repeat (4)
                    doc_buf.push_back(hex_set[$urandom_range(0, hex_set.len() - 1)]);
            end
            else
                doc_buf.push_back(8'($urandom_range(0, CH_SPACE - 1)));
        end
        doc_buf.push_back(CH_QUOTE);
    endfunction

    function automatic void gen_number();
        int r;
        if ($urandom_range(0, 2) == 0)
            doc_buf.push_back(CH_MINUS);
        if ($urandom_range(0, 3) == 0)
            doc_buf.push_back(CH_0);
        else
        begin
            doc_buf.push_back(8'(CH_0 + $urandom_range(1, 9)));
            repeat ($urandom_range(0, 3))
                put_digit();
        end
        if ($urandom_range(0, 2) == 0)
        begin
            doc_buf.push_back(CH_DOT);
            repeat ($urandom_range(1, 3))
                put_digit();
        end
        if ($urandom_range(0, 3) == 0)
        begin
            doc_buf.push_back($urandom_range(0, 1) ? CH_LE : CH_UE);
            r = $urandom_range(0, 2);
            if (r == 1)
                doc_buf.push_back(CH_PLUS);
            else if (r == 2)
                doc_buf.push_back(CH_MINUS);
            repeat ($urandom_range(1, 2))
                put_digit();
        end
    endfunction

    // One element; lvl is the depth of the array around it, room the deepest array built.
    function automatic void gen_value(int lvl, int room);
        int r;
        r = $urandom_range(0, 11);
        if (r < 2 && lvl < room)
            gen_array(lvl + 1, room);
        else if (r < 5)
            gen_string();
        else if (r < 8)
            gen_number();
        else if (r == 8)
            put_text("true");
        else if (r == 9)
            put_text("false");
        else if (r == 10)
            put_text("null");
        else if ($urandom_range(0, 3) == 0)
            doc_buf.push_back(CH_LBRACE);
        else
            gen_number();
    endfunction

    function automatic void gen_array(int lvl, int room);
        int n;
        n = $urandom_range(0, 3);
        doc_buf.push_back(CH_LBRACK);
        for (int i = 0; i < n; i++)
        begin
            gen_value(lvl, room);
            if (i < n - 1)
                doc_buf.push_back(CH_COMMA);
        end
        if (n > 0 && $urandom_range(0, 5) == 0)
            doc_buf.push_back(CH_COMMA);
        doc_buf.push_back(CH_RBRACK);
    endfunction

    // Moves the built document into the pending bytes, marking its final byte.
    function automatic void flush_doc();
        in_item_t it;
        for (int i = 0; i < doc_buf.size(); i++)
        begin
            it.data_byte = doc_buf[i];
            it.last_byte = (i == doc_buf.size() - 1);
            bytes_pending.push_back(it);
        end
        bytes_queued += doc_buf.size();
    endfunction

    function automatic void queue_text(string s);
        doc_buf.delete();
        put_text(s);
        flush_doc();
    endfunction

    // Mostly well-formed arrays with random content, three in eight of them damaged; the rest
    // are bracket towers within or just past the depth limit, raw noise, and single top-level
    // elements that are mostly not arrays. Some documents carry junk after their end.
    function automatic void queue_random_doc(int unsigned lim);
        int kind;
        int pos;
        int room;
        int k;
        doc_buf.delete();
        room = (lim + 1 < 3) ? lim + 1 : 3;
        kind = $urandom_range(0, 19);
        if (kind < 14)
        begin
            gen_array(1, room);
            pos = $urandom_range(0, doc_buf.size() - 1);
            case ($urandom_range(0, 7))
                0:
                    doc_buf[pos] = 8'($urandom_range(0, 255));
                1:
                    doc_buf = doc_buf[0:pos];
                2:
                    doc_buf.insert(pos, CH_SPACE);
                default:
                begin
                end
            endcase
        end
        else if (kind < 16)
        begin
            k = $urandom_range(0, 1) ? lim + 1 : $urandom_range(1, (lim < 4) ? lim : 4);
            repeat (k)
                doc_buf.push_back(CH_LBRACK);
            repeat (k)
                doc_buf.push_back(CH_RBRACK);
        end
        else if (kind < 18)
        begin
            repeat ($urandom_range(1, 6))
                doc_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
            gen_value(1, room);
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 3))
                doc_buf.push_back(8'($urandom_range(0, 255)));
        end
        flush_doc();
    endfunction

    // ------------------------------------------------------------------
    // Byte driver: offers pending bytes, holding each until it is taken, and predicts
    // the verdict of every byte at the edge where the block accepts it.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                verdicts_due.push_back(judge_byte(in_data));
            if (!in_valid || in_ready)
            begin
                if (bytes_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_data <= bytes_pending.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Verdict monitor: stalls the output at random and checks each result request
    // against the oldest predicted verdict.
    // ------------------------------------------------------------------

    function automatic void note_mismatch(string what, out_item_t want, out_item_t got);
        mismatch_count++;
        if (mismatch_count <= MISMATCH_SHOW)
            $display("%0t: %s: expected verdict %0d end %0b, got verdict %0d end %0b",
                     $time, what, want.verdict, want.document_end,
                     got.verdict, got.document_end);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdicts_due.size() == 0)
                    note_mismatch("result with no byte waiting", '0, out_data);
                else
                begin
                    want = verdicts_due.pop_front();
                    verdicts_checked++;
                    if (out_data.verdict !== want.verdict)
                        note_mismatch("verdict differs", want, out_data);
                    else if (out_data.document_end !== want.document_end)
                        note_mismatch("document end differs", want, out_data);
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------

    // Waits until every queued byte has come back as a verdict, then lets the block's
    // queue and result register settle. This is also where the sender stands still.
    task automatic drain();
        while (verdicts_checked != bytes_queued)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // The register is only written while no document is in flight.
    task automatic write_depth_limit(logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_reg = v;
    endtask

    initial
    begin
        int start;
        int goal;
        restart_scan();
        limit_reg = DEPTH_LIMIT_RESET;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed documents under the reset limit: an object at the top level, a valid
        // empty array with a junk byte after it, whitespace, a number cut off by the final
        // byte, and a string with a unicode escape of mixed-case hex digits.
        queue_text("{");
        queue_text("[]x");
        queue_text("[ ");
        queue_text("[-0.5E+7");
        queue_text("[\"\\u0aF9\"]");
        drain();

        // With a limit of one, a nested array is too deep.
        write_depth_limit(7'd1);
        queue_text("[[");

        // Random chunks, each with its own depth limit. The first three stall the output
        // more than the input, the next three the other way round, the last three run flat out.
        goal = BYTE_GOAL / CHUNK_COUNT;
        for (int i = 0; i < CHUNK_COUNT; i++)
        begin
            drain();
            write_depth_limit(limit_plan[i]);
            send_idle_pct <= (i < 3) ? 32 : (i < 6) ? 65 : 0;
            recv_idle_pct <= (i < 3) ? 65 : (i < 6) ? 32 : 0;
            start = bytes_queued;
            while (bytes_queued - start < goal)
                queue_random_doc(allowed_depth(limit_plan[i]));
        end
        drain();

        if (mismatch_count == 0 && verdicts_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog against a block that stops answering.
    initial
    begin
        #(WATCHDOG_TIME);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
